// ===== rtl/wamp_pkg.sv =====
`timescale 1ns / 1ps
// wamp_pkg: shared widths, record summary type, register indexes and back-end states
package wamp_pkg;

   // field widths
   localparam int SAMPLE_W    = 16;
   localparam int ZO_W        = 24;
   localparam int VPC_W       = 32;
   localparam int CSR_W       = 32;
   localparam int OUT_W       = 48;
   localparam int RMS_W       = 47;
   localparam int CNT_OUT_W   = 17;

   // record length limit and sample counter
   localparam int MAX_SAMPLES = 65536;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

   // offset-corrected count, its square (q.12) and the running sums
   localparam int D_W         = SAMPLE_W + 9;
   localparam int SQ_W        = 2 * (D_W - 1) - 4;
   localparam int OSUM_W      = 42;
   localparam int SQSUM_W     = 60;
   localparam int MEAN_W      = D_W + 4;

   // shared multiplier, divider and square root
   localparam int MUL_W       = VPC_W + 1;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DIV_W       = SQSUM_W;
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
   localparam int RAD_W       = SQ_W + 18;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int REM_W       = ROOT_W + 2;
   localparam int STEP_W      = $clog2(ROOT_W);

   // summary queue between front and back
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QLVL_W      = $clog2(QDEPTH + 1);

   // configuration registers
   localparam int CSR_IDX_W   = 1;
   localparam logic signed [ZO_W-1:0]  ZO_RESET  = '0;
   localparam logic signed [VPC_W-1:0] VPC_RESET = VPC_W'(32'h0100_0000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZERO_OFFSET     = 1'b0,
      CSR_VOLTS_PER_COUNT = 1'b1
   } csr_index_type;

   // statistics of one finished record
   typedef struct packed {
      logic [SAMPLE_W-1:0] max_count;
      logic [SAMPLE_W-1:0] min_count;
      logic [OSUM_W-1:0]   offset_sum;
      logic [SQSUM_W-1:0]  square_sum;
      logic [CNT_W-1:0]    count;
      logic                overflow;
   } record_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL_MAX,
      BK_MUL_MIN,
      BK_MEAN_START,
      BK_MEAN_WAIT,
      BK_MUL_MEAN,
      BK_SQ_WAIT,
      BK_SQRT,
      BK_MUL_RMS,
      BK_FINISH
   } back_state_type;

endpackage

// ===== rtl/wamp_front.sv =====
`timescale 1ns / 1ps
// wamp_front: sample intake, squaring pipeline and per-record accumulators
module wamp_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [wamp_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  req_last_sample,
   input  logic signed [wamp_pkg::ZO_W-1:0]      zero_offset,
   input  logic [wamp_pkg::QLVL_W-1:0]           queue_level,
   output logic                                  push,
   output wamp_pkg::record_type                  push_data
);

   localparam logic signed [wamp_pkg::OSUM_W-1:0] OSUM_MAX =
      {1'b0, {(wamp_pkg::OSUM_W-1){1'b1}}};
   localparam logic signed [wamp_pkg::OSUM_W-1:0] OSUM_MIN =
      {1'b1, {(wamp_pkg::OSUM_W-1){1'b0}}};

   logic                                 req_accept;
   logic [wamp_pkg::QLVL_W:0]            pending;

   logic                                 s1_valid_ff;
   logic                                 s1_last_ff;
   logic signed [wamp_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic signed [wamp_pkg::D_W-1:0]      s1_d_ff;
   logic signed [wamp_pkg::D_W-1:0]      s1_d_in;

   logic                                 s2_valid_ff;
   logic                                 s2_last_ff;
   logic signed [wamp_pkg::SAMPLE_W-1:0] s2_sample_ff;
   logic signed [wamp_pkg::D_W-1:0]      s2_d_ff;
   logic [wamp_pkg::SQ_W-1:0]            s2_sq_ff;
   logic signed [2*wamp_pkg::D_W-1:0]    square;

   logic signed [wamp_pkg::SAMPLE_W-1:0] min_ff, min_in;
   logic signed [wamp_pkg::SAMPLE_W-1:0] max_ff, max_in;
   logic signed [wamp_pkg::OSUM_W-1:0]   osum_ff, osum_in;
   logic [wamp_pkg::SQSUM_W-1:0]         sqsum_ff, sqsum_in;
   logic [wamp_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic                                 ovf_ff, ovf_in;
   logic signed [wamp_pkg::OSUM_W:0]     osum_wide;
   logic [wamp_pkg::SQSUM_W:0]           sqsum_wide;

   // hold off new samples while every summary slot is spoken for
   always_comb begin
      pending = (wamp_pkg::QLVL_W+1)'(queue_level)
              + (wamp_pkg::QLVL_W+1)'(s1_valid_ff & s1_last_ff)
              + (wamp_pkg::QLVL_W+1)'(s2_valid_ff & s2_last_ff);
      req_stall  = (pending >= (wamp_pkg::QLVL_W+1)'(wamp_pkg::QDEPTH));
      req_accept = req_valid & ~req_stall;
   end

   // stage 1: offset correction, q.8
   assign s1_d_in = wamp_pkg::D_W'($signed({req_sample, 8'h00}))
                  - wamp_pkg::D_W'(zero_offset);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_sample;
         s1_last_ff   <= req_last_sample;
         s1_d_ff      <= s1_d_in;
      end
   end

   // stage 2: square, truncated to q.12
   assign square = s1_d_ff * s1_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_sample_ff <= s1_sample_ff;
         s2_last_ff   <= s1_last_ff;
         s2_d_ff      <= s1_d_ff;
         s2_sq_ff     <= square[wamp_pkg::SQ_W+3:4];
      end
   end

   // stage 3: saturating accumulation, samples past the limit only flag overflow
   always_comb begin
      min_in   = min_ff;
      max_in   = max_ff;
      osum_in  = osum_ff;
      sqsum_in = sqsum_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;

      osum_wide  = (wamp_pkg::OSUM_W+1)'(osum_ff) + (wamp_pkg::OSUM_W+1)'(s2_d_ff);
      sqsum_wide = {1'b0, sqsum_ff} + (wamp_pkg::SQSUM_W+1)'(s2_sq_ff);

      if (s2_valid_ff) begin
         if (cnt_ff >= wamp_pkg::CNT_W'(wamp_pkg::MAX_SAMPLES)) begin
            ovf_in = 1'b1;
         end else begin
            if (cnt_ff == '0) begin
               min_in = s2_sample_ff;
               max_in = s2_sample_ff;
            end else begin
               if (s2_sample_ff < min_ff) min_in = s2_sample_ff;
               if (s2_sample_ff > max_ff) max_in = s2_sample_ff;
            end
            if (osum_wide[wamp_pkg::OSUM_W] != osum_wide[wamp_pkg::OSUM_W-1]) begin
               osum_in = osum_wide[wamp_pkg::OSUM_W] ? OSUM_MIN : OSUM_MAX;
            end else begin
               osum_in = osum_wide[wamp_pkg::OSUM_W-1:0];
            end
            sqsum_in = sqsum_wide[wamp_pkg::SQSUM_W] ? '1
                                                     : sqsum_wide[wamp_pkg::SQSUM_W-1:0];
            cnt_in   = cnt_ff + 1'b1;
         end
      end

      push                 = s2_valid_ff & s2_last_ff;
      push_data.max_count  = max_in;
      push_data.min_count  = min_in;
      push_data.offset_sum = osum_in;
      push_data.square_sum = sqsum_in;
      push_data.count      = cnt_in;
      push_data.overflow   = ovf_in;
   end

   // record state, cleared when a record closes
   always_ff @(posedge clock) begin
      if (reset || push) begin
         osum_ff  <= '0;
         sqsum_ff <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         osum_ff  <= osum_in;
         sqsum_ff <= sqsum_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   // min and max are reloaded by the first sample of every record
   always_ff @(posedge clock) begin
      min_ff <= min_in;
      max_ff <= max_in;
   end

endmodule

// ===== rtl/wamp_queue.sv =====
`timescale 1ns / 1ps
// wamp_queue: small fifo of record summaries between front and back
module wamp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  wamp_pkg::record_type          push_data,
   input  logic                          pop,
   output wamp_pkg::record_type          pop_data,
   output logic                          not_empty,
   output logic [wamp_pkg::QLVL_W-1:0]   level
);

   wamp_pkg::record_type               entry_ff [wamp_pkg::QDEPTH];
   logic [wamp_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [wamp_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [wamp_pkg::QLVL_W-1:0]        level_ff, level_in;

   // pointer wrap and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == wamp_pkg::QPTR_W'(wamp_pkg::QDEPTH - 1)) ? '0
                                                                        : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == wamp_pkg::QPTR_W'(wamp_pkg::QDEPTH - 1)) ? '0
                                                                        : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = entry_ff[rd_ptr_ff];
   assign not_empty = (level_ff != '0);
   assign level     = level_ff;

endmodule

// ===== rtl/wamp_div.sv =====
`timescale 1ns / 1ps
// wamp_div: restoring divider, one quotient bit per cycle
module wamp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wamp_pkg::DIV_W-1:0]    dividend,
   input  logic [wamp_pkg::CNT_W-1:0]    divisor,
   output logic                          done,
   output logic [wamp_pkg::DIV_W-1:0]    quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [wamp_pkg::DIV_CNT_W-1:0]     iter_ff, iter_in;
   logic [wamp_pkg::DIV_W-1:0]         quo_ff, quo_in;
   logic [wamp_pkg::CNT_W-1:0]         rem_ff, rem_in;
   logic [wamp_pkg::CNT_W-1:0]         dsr_ff, dsr_in;
   logic [wamp_pkg::CNT_W:0]           trial;
   logic [wamp_pkg::CNT_W:0]           diff;
   logic                               fits;

   // one shift-and-subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[wamp_pkg::DIV_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;

      if (start) begin
         busy_in = 1'b1;
         iter_in = wamp_pkg::DIV_CNT_W'(wamp_pkg::DIV_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         iter_in = iter_ff - 1'b1;
         quo_in  = {quo_ff[wamp_pkg::DIV_W-2:0], fits};
         rem_in  = fits ? diff[wamp_pkg::CNT_W-1:0] : trial[wamp_pkg::CNT_W-1:0];
         if (iter_ff == wamp_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/wamp_back.sv =====
`timescale 1ns / 1ps
// wamp_back: per-record sequencer for scaling, mean, root and result register
module wamp_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  queue_not_empty,
   input  wamp_pkg::record_type                  queue_data,
   output logic                                  queue_pop,
   input  logic signed [wamp_pkg::ZO_W-1:0]      zero_offset,
   input  logic signed [wamp_pkg::VPC_W-1:0]     volts_per_count,
   output logic                                  div_start,
   output logic [wamp_pkg::DIV_W-1:0]            div_dividend,
   output logic [wamp_pkg::CNT_W-1:0]            div_divisor,
   input  logic                                  div_done,
   input  logic [wamp_pkg::DIV_W-1:0]            div_quotient,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [wamp_pkg::OUT_W-1:0]     rsp_max_volts,
   output logic signed [wamp_pkg::OUT_W-1:0]     rsp_min_volts,
   output logic signed [wamp_pkg::OUT_W-1:0]     rsp_peak_to_peak,
   output logic signed [wamp_pkg::OUT_W-1:0]     rsp_mean_volts,
   output logic [wamp_pkg::RMS_W-1:0]            rsp_rms_volts,
   output logic [wamp_pkg::CNT_OUT_W-1:0]        rsp_sample_count,
   output logic                                  rsp_count_overflow
);

   localparam int CNTX_W = (wamp_pkg::CNT_W > wamp_pkg::CNT_OUT_W) ? wamp_pkg::CNT_W
                                                                   : wamp_pkg::CNT_OUT_W;
   localparam logic signed [wamp_pkg::PROD_W-1:0] HALF_16 = wamp_pkg::PROD_W'(1 << 15);
   localparam logic signed [wamp_pkg::PROD_W-1:0] HALF_20 = wamp_pkg::PROD_W'(1 << 19);
   localparam logic signed [wamp_pkg::PROD_W-1:0] HALF_23 = wamp_pkg::PROD_W'(1 << 22);

   wamp_pkg::back_state_type              state_ff, state_in;
   wamp_pkg::record_type                  rec_ff, rec_in;

   logic signed [wamp_pkg::MUL_W-1:0]     mul_a, mul_b;
   logic                                  mul_en;
   logic signed [wamp_pkg::PROD_W-1:0]    prod_ff, prod_in;

   logic signed [wamp_pkg::OUT_W-1:0]     vmax_ff, vmax_in;
   logic signed [wamp_pkg::OUT_W-1:0]     vmin_ff, vmin_in;
   logic signed [wamp_pkg::OUT_W-1:0]     peak_ff, peak_in;
   logic signed [wamp_pkg::MEAN_W-1:0]    mean12_ff, mean12_in;
   logic signed [wamp_pkg::OUT_W-1:0]     mean_ff, mean_in;

   logic [wamp_pkg::RAD_W-1:0]            rad_ff, rad_in;
   logic [wamp_pkg::ROOT_W-1:0]           root_ff, root_in;
   logic [wamp_pkg::REM_W-1:0]            rem_ff, rem_in;
   logic [wamp_pkg::STEP_W-1:0]           step_ff, step_in;
   logic [wamp_pkg::REM_W+1:0]            rem_sh, trial;
   logic                                  fits;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  out_load;
   logic signed [wamp_pkg::OUT_W-1:0]     out_max_ff, out_min_ff, out_peak_ff, out_mean_ff;
   logic [wamp_pkg::RMS_W-1:0]            out_rms_ff, rms_in;
   logic [wamp_pkg::CNT_OUT_W-1:0]        out_cnt_ff, cnt_sat;
   logic                                  out_ovf_ff;

   logic signed [wamp_pkg::MUL_W-1:0]     zo_ext, vpc_ext, vpc_mag;
   logic signed [wamp_pkg::MUL_W-1:0]     max_term, min_term;
   logic signed [wamp_pkg::PROD_W-1:0]    rnd16, rnd20, rnd23;
   logic [wamp_pkg::OSUM_W-1:0]           osum_mag;
   logic [wamp_pkg::DIV_W-1:0]            mean_dvd;
   logic [wamp_pkg::MEAN_W-1:0]           q_mean;
   logic [CNTX_W-1:0]                     cnt_x;

   // operands and rounding shared by the sequence
   always_comb begin
      zo_ext   = wamp_pkg::MUL_W'(zero_offset);
      vpc_ext  = wamp_pkg::MUL_W'(volts_per_count);
      vpc_mag  = volts_per_count[wamp_pkg::VPC_W-1] ? -vpc_ext : vpc_ext;
      max_term = wamp_pkg::MUL_W'($signed({rec_ff.max_count, 8'h00})) - zo_ext;
      min_term = wamp_pkg::MUL_W'($signed({rec_ff.min_count, 8'h00})) - zo_ext;

      rnd16 = prod_ff + HALF_16;
      rnd20 = prod_ff + HALF_20;
      rnd23 = prod_ff + HALF_23;
      rms_in = wamp_pkg::RMS_W'(rnd23 >>> 23);

      // mean rounds half away from zero: magnitude plus half the count
      osum_mag = rec_ff.offset_sum[wamp_pkg::OSUM_W-1] ? -rec_ff.offset_sum
                                                       : rec_ff.offset_sum;
      mean_dvd = wamp_pkg::DIV_W'({osum_mag, 4'h0})
               + wamp_pkg::DIV_W'(rec_ff.count >> 1);
      q_mean   = div_quotient[wamp_pkg::MEAN_W-1:0];

      cnt_x   = CNTX_W'(rec_ff.count);
      cnt_sat = (cnt_x > CNTX_W'({wamp_pkg::CNT_OUT_W{1'b1}})) ? '1
                                                              : wamp_pkg::CNT_OUT_W'(cnt_x);

      // digit-by-digit square root step
      rem_sh = {rem_ff, rad_ff[wamp_pkg::RAD_W-1 -: 2]};
      trial  = (wamp_pkg::REM_W+2)'({root_ff, 2'b01});
      fits   = (rem_sh >= trial);

      div_dividend = (state_ff == wamp_pkg::BK_MEAN_START) ? mean_dvd
                                                           : rec_ff.square_sum;
      div_divisor  = rec_ff.count;
   end

   // sequencer: next state and datapath controls
   always_comb begin
      state_in   = state_ff;
      rec_in     = rec_ff;
      vmax_in    = vmax_ff;
      vmin_in    = vmin_ff;
      peak_in    = peak_ff;
      mean12_in  = mean12_ff;
      mean_in    = mean_ff;
      rad_in     = rad_ff;
      root_in    = root_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      mul_a      = '0;
      mul_b      = '0;
      mul_en     = 1'b0;
      queue_pop  = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;

      case (state_ff)
         wamp_pkg::BK_IDLE: begin
            if (queue_not_empty) begin
               queue_pop = 1'b1;
               rec_in    = queue_data;
               state_in  = wamp_pkg::BK_MUL_MAX;
            end
         end
         wamp_pkg::BK_MUL_MAX: begin
            mul_a    = max_term;
            mul_b    = vpc_ext;
            mul_en   = 1'b1;
            state_in = wamp_pkg::BK_MUL_MIN;
         end
         wamp_pkg::BK_MUL_MIN: begin
            vmax_in  = wamp_pkg::OUT_W'(rnd16 >>> 16);
            mul_a    = min_term;
            mul_b    = vpc_ext;
            mul_en   = 1'b1;
            state_in = wamp_pkg::BK_MEAN_START;
         end
         wamp_pkg::BK_MEAN_START: begin
            vmin_in   = wamp_pkg::OUT_W'(rnd16 >>> 16);
            div_start = 1'b1;
            state_in  = wamp_pkg::BK_MEAN_WAIT;
         end
         wamp_pkg::BK_MEAN_WAIT: begin
            peak_in = vmax_ff - vmin_ff;
            if (div_done) begin
               mean12_in = rec_ff.offset_sum[wamp_pkg::OSUM_W-1] ? -q_mean : q_mean;
               state_in  = wamp_pkg::BK_MUL_MEAN;
            end
         end
         wamp_pkg::BK_MUL_MEAN: begin
            mul_a     = wamp_pkg::MUL_W'(mean12_ff);
            mul_b     = vpc_ext;
            mul_en    = 1'b1;
            div_start = 1'b1;
            state_in  = wamp_pkg::BK_SQ_WAIT;
         end
         wamp_pkg::BK_SQ_WAIT: begin
            mean_in = wamp_pkg::OUT_W'(rnd20 >>> 20);
            if (div_done) begin
               rad_in   = {div_quotient[wamp_pkg::SQ_W-1:0], 18'h0};
               root_in  = '0;
               rem_in   = '0;
               step_in  = wamp_pkg::STEP_W'(wamp_pkg::ROOT_W - 1);
               state_in = wamp_pkg::BK_SQRT;
            end
         end
         wamp_pkg::BK_SQRT: begin
            rem_in  = fits ? wamp_pkg::REM_W'(rem_sh - trial) : wamp_pkg::REM_W'(rem_sh);
            root_in = {root_ff[wamp_pkg::ROOT_W-2:0], fits};
            rad_in  = rad_ff << 2;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = wamp_pkg::BK_MUL_RMS;
            end
         end
         wamp_pkg::BK_MUL_RMS: begin
            mul_a    = wamp_pkg::MUL_W'(root_ff);
            mul_b    = vpc_mag;
            mul_en   = 1'b1;
            state_in = wamp_pkg::BK_FINISH;
         end
         wamp_pkg::BK_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = wamp_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = wamp_pkg::BK_IDLE;
         end
      endcase

      prod_in      = mul_a * mul_b;
      rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wamp_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   // working registers of the current record
   always_ff @(posedge clock) begin
      rec_ff    <= rec_in;
      vmax_ff   <= vmax_in;
      vmin_ff   <= vmin_in;
      peak_ff   <= peak_in;
      mean12_ff <= mean12_in;
      mean_ff   <= mean_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      rem_ff    <= rem_in;
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // result register, frees the sequencer while a transaction waits
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_max_ff  <= vmax_ff;
         out_min_ff  <= vmin_ff;
         out_peak_ff <= peak_ff;
         out_mean_ff <= mean_ff;
         out_rms_ff  <= rms_in;
         out_cnt_ff  <= cnt_sat;
         out_ovf_ff  <= rec_ff.overflow;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_max_volts      = out_max_ff;
   assign rsp_min_volts      = out_min_ff;
   assign rsp_peak_to_peak   = out_peak_ff;
   assign rsp_mean_volts     = out_mean_ff;
   assign rsp_rms_volts      = out_rms_ff;
   assign rsp_sample_count   = out_cnt_ff;
   assign rsp_count_overflow = out_ovf_ff;

endmodule

// ===== rtl/waveform_amplitude_stats_core.sv =====
`timescale 1ns / 1ps
// Throughput: one sample per cycle while req_stall is low; the back end finishes each record before
// it takes the next, using two 60-bit divisions in the shared divider and a 31-step square root.
// Two record summaries may wait in the queue; input stalls while two record ends are pending.
// Reset (synchronous): clears record state and the queue, zero offset 0, scale 1.0.
module waveform_amplitude_stats_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [wamp_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  req_last_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [wamp_pkg::OUT_W-1:0]     rsp_max_volts,
   output logic signed [wamp_pkg::OUT_W-1:0]     rsp_min_volts,
   output logic signed [wamp_pkg::OUT_W-1:0]     rsp_peak_to_peak,
   output logic signed [wamp_pkg::OUT_W-1:0]     rsp_mean_volts,
   output logic [wamp_pkg::RMS_W-1:0]            rsp_rms_volts,
   output logic [wamp_pkg::CNT_OUT_W-1:0]        rsp_sample_count,
   output logic                                  rsp_count_overflow,
   input  logic                                  csr_write,
   input  logic [wamp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wamp_pkg::CSR_W-1:0]            csr_data
);

   logic signed [wamp_pkg::ZO_W-1:0]   zero_offset_ff, zero_offset_in;
   logic signed [wamp_pkg::VPC_W-1:0]  vpc_ff, vpc_in;

   logic                               push;
   wamp_pkg::record_type               push_data;
   logic                               pop;
   wamp_pkg::record_type               pop_data;
   logic                               not_empty;
   logic [wamp_pkg::QLVL_W-1:0]        level;

   logic                               div_start;
   logic [wamp_pkg::DIV_W-1:0]         div_dividend;
   logic [wamp_pkg::CNT_W-1:0]         div_divisor;
   logic                               div_done;
   logic [wamp_pkg::DIV_W-1:0]         div_quotient;

   // configuration registers
   always_comb begin
      zero_offset_in = zero_offset_ff;
      vpc_in         = vpc_ff;
      if (csr_write) begin
         case (csr_index)
            wamp_pkg::CSR_ZERO_OFFSET:     zero_offset_in = csr_data[wamp_pkg::ZO_W-1:0];
            wamp_pkg::CSR_VOLTS_PER_COUNT: vpc_in         = csr_data[wamp_pkg::VPC_W-1:0];
            default: begin
               zero_offset_in = zero_offset_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= wamp_pkg::ZO_RESET;
         vpc_ff         <= wamp_pkg::VPC_RESET;
      end else begin
         zero_offset_ff <= zero_offset_in;
         vpc_ff         <= vpc_in;
      end
   end

   // sample intake and accumulation
   wamp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .zero_offset     (zero_offset_ff),
      .queue_level     (level),
      .push            (push),
      .push_data       (push_data)
   );

   // record summaries in flight
   wamp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty),
      .level     (level)
   );

   // shared divider for mean and mean square
   wamp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // per-record result sequencer
   wamp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_not_empty    (not_empty),
      .queue_data         (pop_data),
      .queue_pop          (pop),
      .zero_offset        (zero_offset_ff),
      .volts_per_count    (vpc_ff),
      .div_start          (div_start),
      .div_dividend       (div_dividend),
      .div_divisor        (div_divisor),
      .div_done           (div_done),
      .div_quotient       (div_quotient),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_max_volts      (rsp_max_volts),
      .rsp_min_volts      (rsp_min_volts),
      .rsp_peak_to_peak   (rsp_peak_to_peak),
      .rsp_mean_volts     (rsp_mean_volts),
      .rsp_rms_volts      (rsp_rms_volts),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_count_overflow (rsp_count_overflow)
   );

endmodule

// ===== sim/waveform_amplitude_stats_core_tb.sv =====
`timescale 1ns / 1ps
// waveform_amplitude_stats_core_tb: self-checking bench for the record amplitude statistics core
module waveform_amplitude_stats_core_tb;

   typedef longint unsigned word64_type;

   // one sample transaction waiting to be driven
   typedef struct {
      logic signed [wamp_pkg::SAMPLE_W-1:0] value;
      logic                                 is_last;
   } sample_item_type;

   // statistics expected for one finished record
   typedef struct {
      logic signed [wamp_pkg::OUT_W-1:0]   max_v;
      logic signed [wamp_pkg::OUT_W-1:0]   min_v;
      logic signed [wamp_pkg::OUT_W-1:0]   span_v;
      logic signed [wamp_pkg::OUT_W-1:0]   mean_v;
      logic [wamp_pkg::RMS_W-1:0]          rms_v;
      logic [wamp_pkg::CNT_OUT_W-1:0]      count;
      logic                                overflow;
   } record_stats_type;

   localparam int         CYCLE_LIMIT   = 1_200_000;
   localparam int         SETTLE_CYCLES = 220;
   localparam int         RANDOM_PHASES = 5;
   localparam int         PHASE_ITEMS   = 300;
   localparam longint     OUT_HI        = (longint'(1) <<< (wamp_pkg::OUT_W - 1)) - 1;
   localparam longint     OUT_LO        = -(longint'(1) <<< (wamp_pkg::OUT_W - 1));
   localparam longint     OSUM_HI       = (longint'(1) <<< (wamp_pkg::OSUM_W - 1)) - 1;
   localparam longint     OSUM_LO       = -(longint'(1) <<< (wamp_pkg::OSUM_W - 1));
   localparam word64_type SQSUM_HI      = (64'd1 << wamp_pkg::SQSUM_W) - 1;
   localparam word64_type RMS_HI        = (64'd1 << wamp_pkg::RMS_W) - 1;
   localparam word64_type COUNT_HI      = (64'd1 << wamp_pkg::CNT_OUT_W) - 1;

   // clock and block inputs, all known from time zero
   logic                                  clock            = 1'b0;
   logic                                  reset            = 1'b1;
   logic                                  req_valid        = 1'b0;
   logic signed [wamp_pkg::SAMPLE_W-1:0]  req_sample       = '0;
   logic                                  req_last_sample  = 1'b0;
   logic                                  rsp_stall        = 1'b0;
   logic                                  csr_write        = 1'b0;
   wamp_pkg::csr_index_type               csr_index        = wamp_pkg::CSR_ZERO_OFFSET;
   logic [wamp_pkg::CSR_W-1:0]            csr_data         = '0;

   logic                                  req_stall;
   logic                                  rsp_valid;
   logic signed [wamp_pkg::OUT_W-1:0]     rsp_max_volts;
   logic signed [wamp_pkg::OUT_W-1:0]     rsp_min_volts;
   logic signed [wamp_pkg::OUT_W-1:0]     rsp_peak_to_peak;
   logic signed [wamp_pkg::OUT_W-1:0]     rsp_mean_volts;
   logic [wamp_pkg::RMS_W-1:0]            rsp_rms_volts;
   logic [wamp_pkg::CNT_OUT_W-1:0]        rsp_sample_count;
   logic                                  rsp_count_overflow;

   // bench bookkeeping
   sample_item_type    sample_queue[$];
   sample_item_type    next_item;
   record_stats_type   expected_stats[$];
   record_stats_type   got_stats;
   int                 queued_count   = 0;
   int                 accepted_count = 0;
   int                 mismatch_count = 0;
   int                 cycle_count    = 0;
   int                 send_idle_pct  = 24;
   int                 recv_stall_pct = 24;

   // predictor copy of configuration and record state
   logic signed [wamp_pkg::ZO_W-1:0]      cfg_zero_offset = wamp_pkg::ZO_RESET;
   logic signed [wamp_pkg::VPC_W-1:0]     cfg_scale       = wamp_pkg::VPC_RESET;
   logic signed [wamp_pkg::SAMPLE_W-1:0]  rec_min         = '0;
   logic signed [wamp_pkg::SAMPLE_W-1:0]  rec_max         = '0;
   longint                                rec_offset_sum  = 0;
   word64_type                            rec_square_sum  = 0;
   int                                    rec_seen        = 0;
   logic                                  rec_overflow    = 1'b0;

   waveform_amplitude_stats_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_last_sample    (req_last_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_max_volts      (rsp_max_volts),
      .rsp_min_volts      (rsp_min_volts),
      .rsp_peak_to_peak   (rsp_peak_to_peak),
      .rsp_mean_volts     (rsp_mean_volts),
      .rsp_rms_volts      (rsp_rms_volts),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_count_overflow (rsp_count_overflow),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // cycle counter and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("*** FAILED ***");
      $finish;
   end

   // saturate to the signed output range
   function automatic logic signed [wamp_pkg::OUT_W-1:0] clamp_out(input longint x);
      if (x > OUT_HI) return OUT_HI[wamp_pkg::OUT_W-1:0];
      if (x < OUT_LO) return OUT_LO[wamp_pkg::OUT_W-1:0];
      return x[wamp_pkg::OUT_W-1:0];
   endfunction

   // floor of the square root, result below 2^32
   function automatic word64_type floor_sqrt(input word64_type v);
      word64_type root;
      word64_type trial;
      int         b;
      root = 0;
      for (b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // accumulate one accepted sample; a last sample closes the record
   task automatic predict_sample(input logic signed [wamp_pkg::SAMPLE_W-1:0] s,
                                 input logic is_last);
      longint           d;
      longint           ad;
      word64_type       sq;
      word64_type       n;
      longint           num;
      word64_type       num_mag;
      word64_type       quot;
      longint           mean12;
      word64_type       root;
      word64_type       scale_mag;
      word64_type       rms_wide;
      longint           hi_prod;
      longint           lo_prod;
      record_stats_type e;
      if (rec_seen >= wamp_pkg::MAX_SAMPLES) begin
         rec_overflow = 1'b1;
      end else begin
         d  = longint'(s) * 256 - longint'(cfg_zero_offset);
         ad = (d < 0) ? -d : d;
         sq = word64_type'(ad * ad) >> 4;
         if (rec_seen == 0) begin
            rec_min = s;
            rec_max = s;
         end else begin
            if (s < rec_min) rec_min = s;
            if (s > rec_max) rec_max = s;
         end
         rec_offset_sum = rec_offset_sum + d;
         if (rec_offset_sum > OSUM_HI) rec_offset_sum = OSUM_HI;
         if (rec_offset_sum < OSUM_LO) rec_offset_sum = OSUM_LO;
         rec_square_sum = (SQSUM_HI - rec_square_sum < sq) ? SQSUM_HI : rec_square_sum + sq;
         rec_seen++;
      end
      if (!is_last) return;

      n = word64_type'(rec_seen);
      // max and min: q.32 products rounded half up to q.16
      hi_prod  = (longint'(rec_max) * 256 - longint'(cfg_zero_offset)) * longint'(cfg_scale);
      lo_prod  = (longint'(rec_min) * 256 - longint'(cfg_zero_offset)) * longint'(cfg_scale);
      e.max_v  = clamp_out((hi_prod + 32768) >>> 16);
      e.min_v  = clamp_out((lo_prod + 32768) >>> 16);
      e.span_v = clamp_out(longint'(e.max_v) - longint'(e.min_v));

      // mean: q.12 average rounded away from zero, then scaled and rounded half up
      num     = rec_offset_sum * 16;
      num_mag = (num < 0) ? word64_type'(-num) : word64_type'(num);
      quot    = (n == 0) ? 0 : (num_mag + n / 2) / n;
      mean12  = (num < 0) ? -longint'(quot) : longint'(quot);
      e.mean_v = clamp_out((mean12 * longint'(cfg_scale) + 524288) >>> 20);

      // rms: q.15 root of the mean square times the scale magnitude
      root      = floor_sqrt(((n == 0) ? 0 : rec_square_sum / n) << 18);
      scale_mag = (cfg_scale < 0) ? word64_type'(-longint'(cfg_scale))
                                  : word64_type'(longint'(cfg_scale));
      rms_wide  = (root * scale_mag + (64'd1 << 22)) >> 23;
      e.rms_v   = (rms_wide > RMS_HI) ? RMS_HI[wamp_pkg::RMS_W-1:0]
                                      : rms_wide[wamp_pkg::RMS_W-1:0];

      e.count    = (n > COUNT_HI) ? COUNT_HI[wamp_pkg::CNT_OUT_W-1:0]
                                  : n[wamp_pkg::CNT_OUT_W-1:0];
      e.overflow = rec_overflow;
      expected_stats = {expected_stats, e};

      rec_min        = '0;
      rec_max        = '0;
      rec_offset_sum = 0;
      rec_square_sum = 0;
      rec_seen       = 0;
      rec_overflow   = 1'b0;
   endtask

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // sample driver, fed from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = sample_queue.pop_front();
            req_valid       <= 1'b1;
            req_sample      <= next_item.value;
            req_last_sample <= next_item.is_last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor: check result transactions, predict from sample transactions
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stats.size() == 0) begin
               $display("%0t: result with none expected, expected nothing actual count %0d",
                        $time, rsp_sample_count);
               mismatch_count++;
            end else begin
               got_stats = expected_stats.pop_front();
               check_field("max_volts", 64'(got_stats.max_v), 64'(rsp_max_volts));
               check_field("min_volts", 64'(got_stats.min_v), 64'(rsp_min_volts));
               check_field("peak_to_peak", 64'(got_stats.span_v), 64'(rsp_peak_to_peak));
               check_field("mean_volts", 64'(got_stats.mean_v), 64'(rsp_mean_volts));
               check_field("rms_volts", 64'(got_stats.rms_v), 64'(rsp_rms_volts));
               check_field("sample_count", 64'(got_stats.count), 64'(rsp_sample_count));
               check_field("count_overflow", 64'(got_stats.overflow), 64'(rsp_count_overflow));
            end
         end
         if (req_valid && !req_stall) begin
            accepted_count++;
            predict_sample(req_sample, req_last_sample);
         end
      end
   end

   task automatic add_sample(input logic signed [wamp_pkg::SAMPLE_W-1:0] value,
                             input logic is_last);
      sample_item_type item;
      item.value   = value;
      item.is_last = is_last;
      sample_queue = {sample_queue, item};
      queued_count++;
   endtask

   // one record of len samples, content shaped by style
   task automatic queue_record(input int len, input int style);
      logic [wamp_pkg::SAMPLE_W-1:0] base;
      logic [wamp_pkg::SAMPLE_W-1:0] value;
      int                            i;
      base = wamp_pkg::SAMPLE_W'($urandom);
      for (i = 0; i < len; i++) begin
         case (style)
            0: value = wamp_pkg::SAMPLE_W'($urandom);
            1: value = $urandom_range(1) ? 16'h7FFF - wamp_pkg::SAMPLE_W'($urandom_range(63))
                                          : 16'h8000 + wamp_pkg::SAMPLE_W'($urandom_range(63));
            2: value = wamp_pkg::SAMPLE_W'($urandom_range(512)) - 16'd256;
            default: value = base;
         endcase
         add_sample(value, i == len - 1);
      end
   endtask

   // wait for every transaction and result, then let the back end go quiet
   task automatic drain_and_settle();
      while (accepted_count != queued_count || expected_stats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // write both registers while the block is idle
   task automatic load_config(input logic [wamp_pkg::CSR_W-1:0] zo_data,
                              input logic [wamp_pkg::CSR_W-1:0] vpc_data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= wamp_pkg::CSR_ZERO_OFFSET;
      csr_data  <= zo_data;
      cfg_zero_offset = zo_data[wamp_pkg::ZO_W-1:0];
      @(posedge clock);
      csr_index <= wamp_pkg::CSR_VOLTS_PER_COUNT;
      csr_data  <= vpc_data;
      cfg_scale = vpc_data[wamp_pkg::VPC_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // stimulus and end of run
   initial begin
      int phase;
      int items;
      int len;
      int pick;
      logic [wamp_pkg::CSR_W-1:0] vpc_data;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: single-sample records and field extremes
      add_sample(16'sh7FFF, 1'b1);
      add_sample(-16'sh8000, 1'b1);
      add_sample(16'sh0000, 1'b0);
      add_sample(-16'sh0001, 1'b0);
      add_sample(16'sh0001, 1'b0);
      add_sample(16'sh7FFF, 1'b0);
      add_sample(-16'sh8000, 1'b1);
      add_sample(-16'sh8000, 1'b0);
      add_sample(-16'sh8000, 1'b1);
      drain_and_settle();

      // most negative offset, largest positive scale
      load_config({8'hA5, 24'h800000}, 32'h7FFF_FFFF);
      add_sample(16'sh7FFF, 1'b0);
      add_sample(-16'sh8000, 1'b1);
      add_sample(16'sh7FFF, 1'b1);
      add_sample(16'sh0000, 1'b1);
      drain_and_settle();

      // largest offset, most negative scale
      load_config({8'h5A, 24'h7FFFFF}, 32'h8000_0000);
      add_sample(-16'sh8000, 1'b0);
      add_sample(16'sh7FFF, 1'b1);
      add_sample(-16'sh8000, 1'b1);
      drain_and_settle();

      // random records under a series of settings
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: vpc_data = wamp_pkg::CSR_W'($urandom_range(32'h0400_0000, 32'h0010_0000));
            1: vpc_data = wamp_pkg::CSR_W'($urandom);
            2: vpc_data = '0;
            3: vpc_data = 32'h8000_0000 | wamp_pkg::CSR_W'($urandom);
            default: vpc_data = wamp_pkg::CSR_W'($urandom);
         endcase
         load_config(wamp_pkg::CSR_W'($urandom), vpc_data);
         // one phase runs with neither side idling
         send_idle_pct  = (phase == 1) ? 0 : 24;
         recv_stall_pct = (phase == 1) ? 0 : 24;
         items = 0;
         while (items < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 10) len = 1;
            else if (pick < 75) len = $urandom_range(24, 2);
            else len = $urandom_range(120, 25);
            queue_record(len, $urandom_range(3));
            items += len;
         end
         drain_and_settle();
      end

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== waveform_amplitude_stats_core.f =====
rtl/wamp_pkg.sv
rtl/wamp_front.sv
rtl/wamp_queue.sv
rtl/wamp_div.sv
rtl/wamp_back.sv
rtl/waveform_amplitude_stats_core.sv
sim/waveform_amplitude_stats_core_tb.sv
